[rtl/frapu_pkg.sv]
package frapu_pkg;

   localparam int ADDR_W     = 24;
   localparam int BYTE_W     = 8;
   localparam int MAP_W      = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_IDX_W = $clog2(MAP_W);

   // Access kinds
   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_FETCH  = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   // Fetch violation codes
   localparam logic [1:0] VIOL_NONE     = 2'd0;
   localparam logic [1:0] VIOL_ARCHIVE  = 2'd1;
   localparam logic [1:0] VIOL_RAM_EXEC = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_HW_REVISION  = 2'd0;
   localparam logic [1:0] REG_NOEXEC_MAP   = 2'd1;
   localparam logic [1:0] REG_UPPER_NOEXEC = 2'd2;

   // Stealth windows
   localparam logic [ADDR_W-1:0] WIN_LIMIT_LO   = 24'h040000;
   localparam logic [ADDR_W-1:0] WIN_LIMIT_HI   = 24'h0fffff;
   localparam logic [ADDR_W-1:0] WIN_SCREEN_LO  = 24'h180000;
   localparam logic [ADDR_W-1:0] WIN_SCREEN_HI  = 24'h1bffff;
   localparam logic [ADDR_W-1:0] WIN_TOGGLE_LO  = 24'h1c0000;
   localparam logic [ADDR_W-1:0] WIN_TOGGLE_HI  = 24'h1fffff;
   localparam logic [ADDR_W-1:0] WIN_BOOT_LO    = 24'h200000;
   localparam logic [ADDR_W-1:0] WIN_BOOT_HI    = 24'h20ffff;
   localparam logic [ADDR_W-1:0] WIN_PROT_LO    = 24'h210000;
   localparam logic [ADDR_W-1:0] WIN_PROT_HI    = 24'h211fff;
   localparam logic [ADDR_W-1:0] WIN_AUTH_A_LO  = 24'h212000;
   localparam logic [ADDR_W-1:0] WIN_AUTH_A_HI  = 24'h217fff;
   localparam logic [ADDR_W-1:0] WIN_CERT_LO    = 24'h218000;
   localparam logic [ADDR_W-1:0] WIN_CERT_HI    = 24'h219fff;
   localparam logic [ADDR_W-1:0] WIN_AUTH_B_LO  = 24'h21a000;
   localparam logic [ADDR_W-1:0] WIN_AUTH_B_HI  = 24'h21ffff;
   localparam logic [ADDR_W-1:0] RAM_LOW_HI     = 24'h03ffff;
   localparam logic [ADDR_W-1:0] RAM_UPPER_HI   = 24'h1fffff;
   localparam logic [ADDR_W-1:0] ARCHIVE_TOP    = 24'h3fffff;
   localparam logic [7:0]        ARCHIVE_BASE64K = 8'h39;
   localparam logic [BYTE_W-1:0] PROTECTED_BYTE = 8'h14;

   localparam logic [7:0] AUTH_MAX      = 8'hff;
   localparam logic [7:0] AUTH_FIRST_OK = 8'd3;
   localparam logic [7:0] AUTH_SECOND_OK = 8'd8;
   localparam logic [2:0] CRASH_MAX     = 3'd7;
   localparam logic [2:0] CRASH_LIMIT   = 3'd4;

   typedef struct packed {
      logic       protect;
      logic [2:0] arch_lim;
      logic       screen;
      logic [7:0] auth_first;
      logic [7:0] auth_second;
      logic [2:0] stealth_crash;
      logic [2:0] archive_crash;
   } state_type;

   typedef struct packed {
      logic             hw_revision;
      logic [MAP_W-1:0] noexec_map;
      logic             upper_noexec;
   } cfg_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] memory_byte;
      logic [BYTE_W-1:0] write_byte;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              write_enable;
      logic [BYTE_W-1:0] stored_byte;
      logic [1:0]        fetch_violation;
      logic              halt_request;
      logic              protect_active;
      logic [2:0]        arch_lim_now;
      logic              screen_on;
   } result_type;

   function automatic logic in_win(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] a,
                                   input logic [ADDR_W-1:0] hi);
      return (a >= lo) && (a <= hi);
   endfunction

endpackage

[rtl/frapu_if.sv]
interface frapu_req_if import frapu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [ADDR_W-1:0] address;
   logic [BYTE_W-1:0] memory_byte;
   logic [BYTE_W-1:0] write_byte;

   modport source (output valid, opcode, address, memory_byte, write_byte, input ready);
   modport sink   (input valid, opcode, address, memory_byte, write_byte, output ready);
endinterface

interface frapu_rsp_if import frapu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              write_enable;
   logic [BYTE_W-1:0] stored_byte;
   logic [1:0]        fetch_violation;
   logic              halt_request;
   logic              protect_active;
   logic [2:0]        arch_lim_now;
   logic              screen_on;

   modport source (output valid, read_byte, write_enable, stored_byte, fetch_violation,
                   halt_request, protect_active, arch_lim_now, screen_on,
                   input ready);
   modport sink   (input valid, read_byte, write_enable, stored_byte, fetch_violation,
                   halt_request, protect_active, arch_lim_now, screen_on,
                   output ready);
endinterface

interface frapu_csr_if import frapu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       index;
   logic [MAP_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/frapu_judge.sv]
module frapu_judge import frapu_pkg::*; (
   input  state_type  state_cur,
   input  cfg_type    cfg,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type res
);

   // Advance the authorization counter of the active revision on even addresses
   function automatic state_type count_auth(input state_type s, input logic rev,
                                            input logic odd);
      state_type r;
      r = s;
      if (!odd) begin
         if (!rev) begin
            if (s.auth_first != AUTH_MAX) r.auth_first = s.auth_first + 8'd1;
         end else begin
            if (s.auth_second != AUTH_MAX) r.auth_second = s.auth_second + 8'd1;
         end
      end
      return r;
   endfunction

   logic [ADDR_W-1:0] a;
   logic              is_write;
   logic              prot_win;
   logic              drop;
   logic              halt;
   logic              hit;
   logic [2:0]        lim_bit;
   logic [7:0]        c2_inc;
   logic [2:0]        scc_inc;
   logic [2:0]        acc_inc;
   logic [8:0]        lo_page;
   logic [1:0]        viol;

   assign a        = item.address;
   assign is_write = (item.opcode == OP_WRITE);

   always_comb begin
      state_nxt = state_cur;
      prot_win  = 1'b0;
      drop      = 1'b0;
      halt      = 1'b0;
      hit       = 1'b0;
      lim_bit   = '0;
      c2_inc    = state_cur.auth_second;
      scc_inc   = state_cur.stealth_crash;
      acc_inc   = state_cur.archive_crash;
      lo_page   = '0;
      viol      = VIOL_NONE;

      unique case (item.opcode)
         OP_READ, OP_WRITE: begin
            // Decode the stealth windows
            priority if (in_win(WIN_LIMIT_LO, a, WIN_LIMIT_HI)) begin
               if (!state_cur.protect && !cfg.hw_revision) begin
                  lim_bit = 3'b001 << (a[19:18] - 2'd1);
                  state_nxt.arch_lim = is_write ? (state_cur.arch_lim | lim_bit)
                                                : (state_cur.arch_lim & ~lim_bit);
               end
            end else if (in_win(WIN_SCREEN_LO, a, WIN_SCREEN_HI)) begin
               state_nxt.screen = is_write;
            end else if (in_win(WIN_TOGGLE_LO, a, WIN_TOGGLE_HI)) begin
               c2_inc = (state_cur.auth_second != AUTH_MAX) ? state_cur.auth_second + 8'd1
                                                            : state_cur.auth_second;
               hit = (state_cur.auth_first >= AUTH_FIRST_OK) || (c2_inc == AUTH_SECOND_OK);
               if (hit) begin
                  state_nxt.protect     = !is_write;
                  state_nxt.auth_first  = '0;
                  state_nxt.auth_second = '0;
               end else begin
                  state_nxt.auth_second = c2_inc;
                  if (!cfg.hw_revision) begin
                     scc_inc = (!a[0] && state_cur.stealth_crash != CRASH_MAX)
                               ? state_cur.stealth_crash + 3'd1 : state_cur.stealth_crash;
                     if (scc_inc >= CRASH_LIMIT) begin
                        state_nxt.auth_first    = '0;
                        state_nxt.auth_second   = '0;
                        state_nxt.stealth_crash = '0;
                        halt = 1'b1;
                     end else begin
                        state_nxt.stealth_crash = scc_inc;
                     end
                  end
               end
            end else if (in_win(WIN_BOOT_LO, a, WIN_BOOT_HI)) begin
               state_nxt = count_auth(state_cur, cfg.hw_revision, a[0]);
               drop = 1'b1;
            end else if (in_win(WIN_PROT_LO, a, WIN_PROT_HI)) begin
               prot_win = 1'b1;
            end else if (in_win(WIN_AUTH_A_LO, a, WIN_AUTH_A_HI)) begin
               state_nxt = count_auth(state_cur, cfg.hw_revision, a[0]);
            end else if (in_win(WIN_CERT_LO, a, WIN_CERT_HI)) begin
               prot_win = 1'b1;
               drop     = 1'b1;
            end else if (in_win(WIN_AUTH_B_LO, a, WIN_AUTH_B_HI)) begin
               state_nxt = count_auth(state_cur, cfg.hw_revision, a[0]);
            end else begin
               state_nxt.auth_first    = '0;
               state_nxt.auth_second   = '0;
               state_nxt.stealth_crash = '0;
               state_nxt.archive_crash = '0;
            end
         end
         OP_FETCH: begin
            if (!cfg.hw_revision) begin
               // Archive limit: 64 KiB blocks from 0x39 plus limit up to the top
               lo_page = {1'b0, ARCHIVE_BASE64K} + {6'd0, state_cur.arch_lim};
               if ({1'b0, a[23:16]} >= lo_page && a <= ARCHIVE_TOP) begin
                  acc_inc = (!a[0] && state_cur.archive_crash != CRASH_MAX)
                            ? state_cur.archive_crash + 3'd1 : state_cur.archive_crash;
                  state_nxt.archive_crash = acc_inc;
                  if (acc_inc >= CRASH_LIMIT) begin
                     state_nxt.auth_first    = '0;
                     state_nxt.auth_second   = '0;
                     state_nxt.stealth_crash = '0;
                     viol = VIOL_ARCHIVE;
                  end
               end
            end else begin
               // RAM execution protection
               if (a <= RAM_LOW_HI) begin
                  if (cfg.noexec_map[a[PAGE_SHIFT +: PAGE_IDX_W]]) viol = VIOL_RAM_EXEC;
               end else if (a <= RAM_UPPER_HI) begin
                  if (cfg.upper_noexec) viol = VIOL_RAM_EXEC;
               end
               if (viol != VIOL_NONE) begin
                  state_nxt.auth_first    = '0;
                  state_nxt.auth_second   = '0;
                  state_nxt.stealth_crash = '0;
               end
            end
            halt = (viol != VIOL_NONE);
         end
         OP_UNUSED: begin
         end
      endcase

      // Build the result word
      res.read_byte         = (item.opcode != OP_READ) ? '0
                            : (prot_win && state_nxt.protect) ? PROTECTED_BYTE
                            : item.memory_byte;
      res.write_enable      = is_write && !drop;
      res.stored_byte       = (is_write && !drop) ? item.write_byte : '0;
      res.fetch_violation   = viol;
      res.halt_request      = halt;
      res.protect_active    = state_nxt.protect;
      res.arch_lim_now      = state_nxt.arch_lim;
      res.screen_on         = state_nxt.screen;
   end

endmodule

[rtl/flash_ram_access_protection_unit.sv]
// Access protection unit for a flash and RAM byte bus.
//
// req_bus carries one bus access per word: opcode (read, write, fetch check),
// address, the byte memory holds there and the byte to write. rsp_bus returns
// one result word per access: the delivered read byte, the write enable and
// byte passed on to memory, the fetch violation code, a halt request and the
// protection, archive limit and screen flags after the access.
// csr_bus writes the revision, RAM page no-exec map and upper RAM no-exec bit;
// write it only while no access is in flight.
//
// An accepted word waits in the input register, is judged there by a
// single pass of logic against the protection state and lands in the result
// register; the unit takes one access per cycle while rsp_bus does not stall.
// When rsp_bus stalls, the result register holds and one more access waits in
// the input register; req_bus.ready drops only when both are full.
// Reset (synchronous) empties both registers, turns protection and screen on,
// clears the archive limit, all counters and the configuration.
module flash_ram_access_protection_unit import frapu_pkg::*; (
   input logic          clock,
   input logic          reset,
   frapu_req_if.sink    req_bus,
   frapu_rsp_if.source  rsp_bus,
   frapu_csr_if.sink    csr_bus
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   result_type res_in;
   logic       advance;
   logic       req_fire;

   // Judge the held word when the result register is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_fire = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   frapu_judge u_judge (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .res       (res_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_fire) begin
         in_item_ff.opcode      <= opcode_type'(req_bus.opcode);
         in_item_ff.address     <= req_bus.address;
         in_item_ff.memory_byte <= req_bus.memory_byte;
         in_item_ff.write_byte  <= req_bus.write_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   // Protection state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.protect       <= 1'b1;
         state_ff.arch_lim      <= '0;
         state_ff.screen        <= 1'b1;
         state_ff.auth_first    <= '0;
         state_ff.auth_second   <= '0;
         state_ff.stealth_crash <= '0;
         state_ff.archive_crash <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            REG_HW_REVISION:  cfg_ff.hw_revision  <= csr_bus.data[0];
            REG_NOEXEC_MAP:   cfg_ff.noexec_map   <= csr_bus.data;
            REG_UPPER_NOEXEC: cfg_ff.upper_noexec <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // Drive the result channel
   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.read_byte         = out_res_ff.read_byte;
   assign rsp_bus.write_enable      = out_res_ff.write_enable;
   assign rsp_bus.stored_byte       = out_res_ff.stored_byte;
   assign rsp_bus.fetch_violation   = out_res_ff.fetch_violation;
   assign rsp_bus.halt_request      = out_res_ff.halt_request;
   assign rsp_bus.protect_active    = out_res_ff.protect_active;
   assign rsp_bus.arch_lim_now      = out_res_ff.arch_lim_now;
   assign rsp_bus.screen_on         = out_res_ff.screen_on;

endmodule
